>>> src/ipfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfd_pkg
// Shared types, constants and timing helpers for the IR pulse frame decoder.
// ----------------------------------------------------------------------------
package ipfd_pkg;

    localparam int DUR_W        = 15;
    localparam int FRAME_PAIRS  = 18;
    localparam int PAYLOAD_BITS = 16;
    localparam int COUNT_W      = 5;
    localparam int CFG_IDX_W    = 4;
    localparam int S_DATA_W     = 32;
    localparam int M_DATA_W     = 24;

    typedef enum logic [1:0] {
        ST_DECODED    = 2'd0,
        ST_LEADER_BAD = 2'd1,
        ST_BAD_LENGTH = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEAD_MARK  = 4'd0,
        REG_LEAD_SPACE = 4'd1,
        REG_ZERO_MARK  = 4'd2,
        REG_ZERO_SPACE = 4'd3,
        REG_ONE_MARK   = 4'd4,
        REG_ONE_SPACE  = 4'd5,
        REG_TOLERANCE  = 4'd6,
        REG_INVERT     = 4'd7
    } cfg_reg_t;

    // classified pulse pair, front to back
    typedef struct packed {
        logic leader_fit;
        logic one_bit;
        logic last;
    } pair_class_t;

    // strict window: t - m < d < t + m, never when m > t
    function automatic logic near_target(
        input logic [DUR_W-1:0] d,
        input logic [DUR_W-1:0] t,
        input logic [DUR_W-1:0] m
    );
        logic [DUR_W:0] lo;
        logic [DUR_W:0] hi;
        lo = {1'b0, t} - {1'b0, m};
        hi = {1'b0, t} + {1'b0, m};
        if (m > t)
            return 1'b0;
        return ({1'b0, d} > lo) && ({1'b0, d} < hi);
    endfunction

endpackage
`default_nettype wire

>>> src/ipfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfd_front
// Holds the timing registers and classifies each incoming pulse pair beat.
// ----------------------------------------------------------------------------
module ipfd_front
    import ipfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DUR_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 q_full,
    output logic                      q_push,
    output pair_class_t               q_push_data
);

    logic [DUR_W-1:0] lead_mark_reg;
    logic [DUR_W-1:0] lead_space_reg;
    logic [DUR_W-1:0] zero_mark_reg;
    logic [DUR_W-1:0] zero_space_reg;
    logic [DUR_W-1:0] one_mark_reg;
    logic [DUR_W-1:0] one_space_reg;
    logic [DUR_W-1:0] tol_reg;
    logic             invert_reg;

    logic             first_level;
    logic [DUR_W-1:0] first_duration;
    logic             second_level;
    logic [DUR_W-1:0] second_duration;
    logic             level_ok;
    logic             lead_fit;
    logic             zero_fit;
    logic             one_fit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_mark_reg  <= '0;
            lead_space_reg <= '0;
            zero_mark_reg  <= '0;
            zero_space_reg <= '0;
            one_mark_reg   <= '0;
            one_space_reg  <= '0;
            tol_reg        <= '0;
            invert_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LEAD_MARK:  lead_mark_reg  <= cfg_data;
                REG_LEAD_SPACE: lead_space_reg <= cfg_data;
                REG_ZERO_MARK:  zero_mark_reg  <= cfg_data;
                REG_ZERO_SPACE: zero_space_reg <= cfg_data;
                REG_ONE_MARK:   one_mark_reg   <= cfg_data;
                REG_ONE_SPACE:  one_space_reg  <= cfg_data;
                REG_TOLERANCE:  tol_reg        <= cfg_data;
                REG_INVERT:     invert_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign first_level     = s_tdata[0];
    assign first_duration  = s_tdata[15:1];
    assign second_level    = s_tdata[16];
    assign second_duration = s_tdata[31:17];

    assign level_ok = (first_level == invert_reg) && (second_level != invert_reg);
    assign lead_fit = level_ok
                    && near_target(first_duration, lead_mark_reg, tol_reg)
                    && near_target(second_duration, lead_space_reg, tol_reg);
    assign zero_fit = level_ok
                    && near_target(first_duration, zero_mark_reg, tol_reg)
                    && near_target(second_duration, zero_space_reg, tol_reg);
    assign one_fit  = level_ok
                    && near_target(first_duration, one_mark_reg, tol_reg)
                    && near_target(second_duration, one_space_reg, tol_reg);

    assign s_tready               = !q_full;
    assign q_push                 = s_tvalid && !q_full;
    assign q_push_data.leader_fit = lead_fit;
    assign q_push_data.one_bit    = one_fit && !zero_fit;
    assign q_push_data.last       = s_tlast;

endmodule
`default_nettype wire

>>> src/ipfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfd_queue
// Two-entry queue of classified pairs between front and back.
// ----------------------------------------------------------------------------
module ipfd_queue
    import ipfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire pair_class_t push_data,
    output logic             full,
    input  wire logic        pop,
    output logic             pop_valid,
    output pair_class_t      pop_data
);

    pair_class_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> src/ipfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfd_back
// Frame state: counts pairs, collects payload bits, registers the result beat.
// ----------------------------------------------------------------------------
module ipfd_back
    import ipfd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire pair_class_t         q_data,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(FRAME_PAIRS - 1);
    localparam logic [COUNT_W-1:0] BITS_TOP   = COUNT_W'(PAYLOAD_BITS);

    logic [COUNT_W-1:0]      pair_count_reg;
    logic [COUNT_W-1:0]      pair_count_next;
    logic                    leader_good_reg;
    logic                    leader_good_next;
    logic [PAYLOAD_BITS-1:0] bit_shift_reg;
    logic [PAYLOAD_BITS-1:0] bit_shift_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [M_DATA_W-1:0]     m_data_reg;
    logic [M_DATA_W-1:0]     m_data_next;
    logic [3:0]              bit_pos;
    status_t                 status;
    logic [7:0]              address;
    logic [7:0]              command;

    assign q_pop   = q_valid && (!q_data.last || !m_valid_reg || m_tready);
    assign bit_pos = 4'(pair_count_reg - COUNT_W'(1));

    always_comb
    begin
        status  = ST_DECODED;
        address = bit_shift_reg[7:0];
        command = bit_shift_reg[15:8];
        if (pair_count_reg != LAST_COUNT)
        begin
            status  = ST_BAD_LENGTH;
            address = '0;
            command = '0;
        end
        else if (!leader_good_reg)
        begin
            status  = ST_LEADER_BAD;
            address = '0;
            command = '0;
        end
    end

    always_comb
    begin
        pair_count_next  = pair_count_reg;
        leader_good_next = leader_good_reg;
        bit_shift_next   = bit_shift_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        if (q_pop)
        begin
            if (pair_count_reg == '0)
                leader_good_next = q_data.leader_fit;
            else if (pair_count_reg <= BITS_TOP)
                bit_shift_next = bit_shift_reg
                               | (PAYLOAD_BITS'(q_data.one_bit) << bit_pos);
            if (pair_count_reg != COUNT_MAX)
                pair_count_next = pair_count_reg + COUNT_W'(1);
            if (q_data.last)
            begin
                m_valid_next     = 1'b1;
                m_data_next      = {6'b0, command, address, status};
                pair_count_next  = '0;
                leader_good_next = 1'b0;
                bit_shift_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg  <= '0;
            leader_good_reg <= 1'b0;
            bit_shift_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            pair_count_reg  <= pair_count_next;
            leader_good_reg <= leader_good_next;
            bit_shift_reg   <= bit_shift_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

>>> src/ir_pulse_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder
// Decodes infrared frames given as a stream of captured pulse pairs.
// ----------------------------------------------------------------------------
// One pulse pair beat is taken per clock while the queue has room; the pair is
// classified against the timing registers in the cycle it is accepted, passes a
// two-entry queue, and is folded into the frame state by the back end, one pair
// per cycle unless stalled by the output. The result beat (status, address,
// command) is registered when the back end takes the frame's last pair with the
// output free, and is held until taken; input beats flow on while it waits,
// until the next frame's last pair reaches the back end and the queue fills.
// Configuration writes are always ready and take effect on the next cycle.
module ir_pulse_frame_decoder
    import ipfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DUR_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // first_level, first_duration[14:0], second_level, second_duration[14:0]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[1:0], address[7:0], command[7:0], zero pad[5:0]
    output logic [M_DATA_W-1:0]       m_tdata
);

    logic        q_push;
    pair_class_t q_push_data;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    pair_class_t q_data;

    ipfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    ipfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    ipfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

>>> src/ipfd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfd_checker
// Port-level checks on the result stream of the decoder.
// ----------------------------------------------------------------------------
module ipfd_checker
    import ipfd_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ST_DECODED) |-> (m_tdata[17:2] == '0))
        else $error("address or command nonzero on error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'b11))
        else $error("undefined status code");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_DATA_W-1:18] == '0))
        else $error("pad bits nonzero");

endmodule

bind ir_pulse_frame_decoder ipfd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
